/* hw/rtl/s20_pkg.sv */
// shared types, tables and helpers for the salsa20 keystream engine
`default_nettype none

package s20_pkg;

    // default number of rounds
    localparam int S20_ROUNDS = 20;

    // sixteen 32-bit state words, word k at [k]
    typedef logic [15:0][31:0] words_t;

    // keystream memory write port
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } ks_wr_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_FINAL
    } core_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GEN,
        ST_READ,
        ST_SEND
    } ctl_state_t;

    typedef enum logic [2:0] {
        CFG_KEY_A = 3'd0,
        CFG_KEY_B = 3'd1,
        CFG_KEY_C = 3'd2,
        CFG_KEY_D = 3'd3,
        CFG_NONCE = 3'd4,
        CFG_MODE  = 3'd5
    } cfg_reg_t;

    // state word held at each register slot in column-round layout:
    // four quarter-round groups, each in (a, b, c, d) order
    localparam logic [3:0] COL_ORDER [16] = '{
        4'd0,  4'd4,  4'd8,  4'd12,
        4'd5,  4'd9,  4'd13, 4'd1,
        4'd10, 4'd14, 4'd2,  4'd6,
        4'd15, 4'd3,  4'd7,  4'd11
    };

    // slot shuffle between column layout and row layout (its own inverse)
    localparam logic [3:0] HALF_PERM [16] = '{
        4'd0,  4'd7,  4'd10, 4'd13,
        4'd4,  4'd11, 4'd14, 4'd1,
        4'd8,  4'd15, 4'd2,  4'd5,
        4'd12, 4'd3,  4'd6,  4'd9
    };

    localparam logic [31:0] CONST_W0      = 32'h6170_7865;
    localparam logic [31:0] CONST_W15     = 32'h6b20_6574;
    localparam logic [31:0] SIGMA_W5      = 32'h3320_646e;
    localparam logic [31:0] SIGMA_W10     = 32'h7962_2d32;
    localparam logic [31:0] TAU_W5        = 32'h3120_646e;
    localparam logic [31:0] TAU_W10       = 32'h7962_2d36;

    // rotate left by 7, 9, 13 or 18 for steps 0..3 of a quarter round
    function automatic logic [31:0] rotl_step(input logic [31:0] v, input logic [1:0] sel);
        logic [31:0] r;
        case (sel)
            2'd0:    r = {v[24:0], v[31:25]};
            2'd1:    r = {v[22:0], v[31:23]};
            2'd2:    r = {v[18:0], v[31:19]};
            default: r = {v[13:0], v[31:14]};
        endcase
        return r;
    endfunction

    // initial block matrix from key, nonce, counter and key size
    function automatic words_t build_init(
        input logic [63:0] key_a,
        input logic [63:0] key_b,
        input logic [63:0] key_c,
        input logic [63:0] key_d,
        input logic [63:0] nonce,
        input logic [63:0] counter,
        input logic        long_key
    );
        words_t      w;
        logic [63:0] hi_a;
        logic [63:0] hi_b;
        hi_a  = long_key ? key_c : key_a;
        hi_b  = long_key ? key_d : key_b;
        w[0]  = CONST_W0;
        w[1]  = key_a[31:0];
        w[2]  = key_a[63:32];
        w[3]  = key_b[31:0];
        w[4]  = key_b[63:32];
        w[5]  = long_key ? SIGMA_W5 : TAU_W5;
        w[6]  = nonce[31:0];
        w[7]  = nonce[63:32];
        w[8]  = counter[31:0];
        w[9]  = counter[63:32];
        w[10] = long_key ? SIGMA_W10 : TAU_W10;
        w[11] = hi_a[31:0];
        w[12] = hi_a[63:32];
        w[13] = hi_b[31:0];
        w[14] = hi_b[63:32];
        w[15] = CONST_W15;
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/s20_core.sv */
// salsa20 block function: one add-rotate-xor step per cycle, then 16 final adds
`default_nettype none

module s20_core #(
    parameter int ROUND_COUNT = s20_pkg::S20_ROUNDS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire s20_pkg::words_t  init_words,
    output      logic             done,
    output      s20_pkg::ks_wr_t  ks_wr
);
    import s20_pkg::*;

    localparam int DOUBLE_ROUNDS = (ROUND_COUNT + 1) / 2;
    localparam int DR_W          = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    core_state_t      state_reg, state_next;
    words_t           st_reg, st_next;
    logic [4:0]       step_cnt_reg, step_cnt_next;
    logic [DR_W-1:0]  dr_cnt_reg, dr_cnt_next;
    logic [3:0]       fin_cnt_reg, fin_cnt_next;

    logic [31:0]      op_b;
    logic [31:0]      sum;
    words_t           stepped;
    words_t           shifted;
    words_t           permuted;
    words_t           loaded;
    words_t           fin_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CS_IDLE;
            step_cnt_reg <= '0;
            dr_cnt_reg   <= '0;
            fin_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
            dr_cnt_reg   <= dr_cnt_next;
            fin_cnt_reg  <= fin_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    // shared adder: window words during rounds, feed-forward during finish
    always_comb
    begin
        op_b = (state_reg == CS_FINAL) ? init_words[COL_ORDER[fin_cnt_reg]] : st_reg[3];
        sum  = st_reg[0] + op_b;

        // slot 1 absorbs the rotated sum, then the window turns by one
        stepped    = st_reg;
        stepped[0] = st_reg[1] ^ rotl_step(sum, step_cnt_reg[1:0]);
        stepped[1] = st_reg[2];
        stepped[2] = st_reg[3];
        stepped[3] = st_reg[0];

        // next quarter-round group moves into the window
        for (int k = 0; k < 12; k++)
        begin
            shifted[k] = stepped[k + 4];
        end
        for (int k = 0; k < 4; k++)
        begin
            shifted[k + 12] = stepped[k];
        end

        for (int k = 0; k < 16; k++)
        begin
            permuted[k]  = shifted[HALF_PERM[k]];
            loaded[k]    = init_words[COL_ORDER[k]];
            fin_shift[k] = st_reg[(k + 1) % 16];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        st_next       = st_reg;
        step_cnt_next = step_cnt_reg;
        dr_cnt_next   = dr_cnt_reg;
        fin_cnt_next  = fin_cnt_reg;
        done          = 1'b0;
        ks_wr.en      = 1'b0;
        ks_wr.addr    = COL_ORDER[fin_cnt_reg];
        ks_wr.data    = sum;

        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    st_next       = loaded;
                    step_cnt_next = '0;
                    dr_cnt_next   = '0;
                    state_next    = CS_ROUND;
                end
            end
            CS_ROUND:
            begin
                if (step_cnt_reg[3:0] == 4'd15)
                begin
                    st_next = permuted;
                end
                else if (step_cnt_reg[1:0] == 2'd3)
                begin
                    st_next = shifted;
                end
                else
                begin
                    st_next = stepped;
                end
                step_cnt_next = step_cnt_reg + 5'd1;
                if (step_cnt_reg == 5'd31)
                begin
                    if (dr_cnt_reg == DR_W'(DOUBLE_ROUNDS - 1))
                    begin
                        fin_cnt_next = '0;
                        state_next   = CS_FINAL;
                    end
                    else
                    begin
                        dr_cnt_next = dr_cnt_reg + DR_W'(1);
                    end
                end
            end
            CS_FINAL:
            begin
                ks_wr.en     = 1'b1;
                st_next      = fin_shift;
                fin_cnt_next = fin_cnt_reg + 4'd1;
                if (fin_cnt_reg == 4'd15)
                begin
                    done       = 1'b1;
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/s20_ksmem.sv */
// 16 x 32 keystream block memory with registered read
`default_nettype none

module s20_ksmem (
    input  wire logic             clk,
    input  wire s20_pkg::ks_wr_t  wr,
    input  wire logic [3:0]       rd_addr,
    output      logic [31:0]      rd_data
);
    import s20_pkg::*;

    logic [31:0] ks_mem_reg [16];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            ks_mem_reg[wr.addr] <= wr.data;
        end
        rd_data_reg <= ks_mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/salsa20_stream_cipher.sv */
// top level: salsa20 byte-stream encrypt/decrypt with config registers
//
// usage
//   in channel (in_valid/in_ready) carries one byte per beat plus message_end
//   and empty_call; out channel (out_valid/out_ready) returns result_byte and
//   result_last, one beat per data byte and none for an empty-message beat.
//   config channel (cfg_valid/cfg_ready, always ready) writes key words,
//   nonce and key size by cfg_index; a nonce write clears the block counter
//   and drops any buffered keystream.
// flow
//   buffered keystream: a byte is taken only in the idle state, then its keystream
//   word is read and the result loaded into the output register before the next
//   byte is accepted. a new block runs ROUND_COUNT rounds (odd counts round up):
//   one add-rotate-xor step per cycle on the single shared unit, then the same
//   adder does the 16 feed-forward adds into keystream memory.
// reset / stall
//   reset clears counter, byte position, buffered-block flag and out_valid;
//   the key size resets to 256-bit. while the receiver stalls, a finished
//   result sits in the output register; one more byte may be taken and it
//   waits before the output until that register frees up.
`default_nettype none

module salsa20_stream_cipher #(
    parameter int ROUND_COUNT = s20_pkg::S20_ROUNDS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config write channel
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    // input channel
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        message_end,
    input  wire logic        empty_call,
    // output channel
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [7:0]  result_byte,
    output      logic        result_last
);
    import s20_pkg::*;

    // config registers
    logic [63:0] key_a_reg, key_b_reg, key_c_reg, key_d_reg, nonce_reg;
    logic        long_key_reg;

    // control state
    ctl_state_t  state_reg, state_next;
    logic [63:0] counter_reg, counter_next;
    logic [5:0]  pos_reg, pos_next;
    logic        pending_reg, pending_next;
    logic        out_valid_reg, out_valid_next;

    // held item and result payload
    logic [7:0]  item_data_reg;
    logic        item_last_reg;
    logic        item_empty_reg;
    logic [7:0]  res_byte_reg;
    logic        res_last_reg;

    logic        in_beat;
    logic        out_free;
    logic        load_out;
    logic        core_start;
    logic        core_done;
    words_t      init_words;
    ks_wr_t      ks_wr;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == ST_IDLE);
    assign in_beat     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign result_byte = res_byte_reg;
    assign result_last = res_last_reg;
    assign out_free    = !out_valid_reg || out_ready;

    assign init_words = build_init(key_a_reg, key_b_reg, key_c_reg, key_d_reg,
                                   nonce_reg, counter_reg, long_key_reg);

    s20_core #(
        .ROUND_COUNT (ROUND_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (core_start),
        .init_words (init_words),
        .done       (core_done),
        .ks_wr      (ks_wr)
    );

    s20_ksmem u_ksmem (
        .clk     (clk),
        .wr      (ks_wr),
        .rd_addr (pos_reg[5:2]),
        .rd_data (ks_word)
    );

    // keystream byte within the word, little-endian
    assign ks_byte = ks_word[{pos_reg[1:0], 3'b000} +: 8];

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg    <= '0;
            key_b_reg    <= '0;
            key_c_reg    <= '0;
            key_d_reg    <= '0;
            nonce_reg    <= '0;
            long_key_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_A: key_a_reg    <= cfg_data;
                CFG_KEY_B: key_b_reg    <= cfg_data;
                CFG_KEY_C: key_c_reg    <= cfg_data;
                CFG_KEY_D: key_d_reg    <= cfg_data;
                CFG_NONCE: nonce_reg    <= cfg_data;
                CFG_MODE:  long_key_reg <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            pos_reg       <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            pos_reg       <= pos_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            item_data_reg  <= data_byte;
            item_last_reg  <= message_end;
            item_empty_reg <= empty_call;
        end
        if (load_out)
        begin
            res_byte_reg <= item_data_reg ^ ks_byte;
            res_last_reg <= item_last_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        pos_next       = pos_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg && !out_ready;
        core_start     = 1'b0;
        load_out       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (empty_call)
                    begin
                        // empty message: drop buffered block, burn one counter value
                        pending_next = 1'b0;
                        pos_next     = '0;
                        core_start   = 1'b1;
                        state_next   = ST_GEN;
                    end
                    else if (!pending_reg)
                    begin
                        core_start = 1'b1;
                        state_next = ST_GEN;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_GEN:
            begin
                if (core_done)
                begin
                    counter_next = counter_reg + 64'd1;
                    if (item_empty_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pending_next = 1'b1;
                        pos_next     = '0;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                // keystream word read lands at this edge
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    if (item_last_reg || (pos_reg == 6'd63))
                    begin
                        pending_next = 1'b0;
                        pos_next     = '0;
                    end
                    else
                    begin
                        pos_next = pos_reg + 6'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // nonce write restarts the stream; write it only while idle (not enforced)
        if (cfg_valid && cfg_ready && (cfg_index == CFG_NONCE))
        begin
            counter_next = '0;
            pending_next = 1'b0;
            pos_next     = '0;
        end
    end

endmodule

`default_nettype wire
